// ===== design/hwd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hwd_pkg: shared types and constants of the Huffman tree-walk decoder
// Node entry layout, command format between front and back, and helpers.
// ----------------------------------------------------------------------------
package hwd_pkg;

  // Number of node table entries (2 to 512).
  localparam int MAX_NODES   = 512;
  localparam int NODE_AW     = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

  // Field widths fixed by the item formats.
  localparam int IDX_W       = 9;
  localparam int CHILD_W     = 10;
  localparam int SYM_W       = 8;

  // Depth of the command queue between front and back (power of two).
  localparam int QUEUE_DEPTH = 4;
  localparam int QA_W        = $clog2(QUEUE_DEPTH);

  localparam logic [IDX_W:0] MAX_NODES_W = (IDX_W + 1)'(MAX_NODES);

  // Opcode values of an input item.
  localparam logic OPC_WRITE  = 1'b0;
  localparam logic OPC_DECODE = 1'b1;

  typedef struct packed {
    logic [CHILD_W-1:0] left;
    logic [CHILD_W-1:0] right;
    logic [SYM_W-1:0]   symbol;
  } entry_t;

  // An entry whose children are both missing; used for a root out of range.
  localparam entry_t MISSING_ENTRY = '{
    left:   {1'b1, {(CHILD_W-1){1'b0}}},
    right:  {1'b1, {(CHILD_W-1){1'b0}}},
    symbol: '0
  };

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_BIT   = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic               wr_ok;
    logic [NODE_AW-1:0] wr_addr;
    entry_t             wr_entry;
    logic               code_bit;
  } cmd_t;

  // Status of the back end, watched at the top level.
  typedef struct packed {
    logic loading;
    logic stale;
  } hwd_stat_t;

  function automatic logic idx_in_range(input logic [IDX_W-1:0] idx);
    return {1'b0, idx} < MAX_NODES_W;
  endfunction

  // A child reference is usable when non-negative and inside the table.
  function automatic logic child_present(input logic [CHILD_W-1:0] c);
    return !c[CHILD_W-1] && idx_in_range(c[IDX_W-1:0]);
  endfunction

endpackage

// ===== design/hwd_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hwd_ifs: item channels of the Huffman tree-walk decoder
// Input channel (node writes and code bits) and result channel.
// ----------------------------------------------------------------------------
interface hwd_in_if;
  logic              valid;
  logic              ready;
  logic              opcode;
  logic [8:0]        node_index;
  logic signed [9:0] left_child;
  logic signed [9:0] right_child;
  logic [7:0]        node_symbol;
  logic              code_bit;

  modport source (
    output valid, opcode, node_index, left_child, right_child, node_symbol, code_bit,
    input  ready
  );
  modport sink (
    input  valid, opcode, node_index, left_child, right_child, node_symbol, code_bit,
    output ready
  );
endinterface

interface hwd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] decoded_symbol;
  logic       bad_path;

  modport source (
    output valid, decoded_symbol, bad_path,
    input  ready
  );
  modport sink (
    input  valid, decoded_symbol, bad_path,
    output ready
  );
endinterface

// ===== design/hwd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hwd_front: input classification
// Turns an input item into a write or a bit command for the queue.
// ----------------------------------------------------------------------------
module hwd_front (
  hwd_in_if.sink        in_ch,
  output hwd_pkg::cmd_t cmd,
  output logic          cmd_valid,
  input  logic          cmd_ready
);
  import hwd_pkg::*;

  assign cmd_valid   = in_ch.valid;
  assign in_ch.ready = cmd_ready;

  always_comb begin
    cmd.kind            = (in_ch.opcode == OPC_DECODE) ? CMD_BIT : CMD_WRITE;
    // Writes beyond the table are dropped but still send the walk home.
    cmd.wr_ok           = idx_in_range(in_ch.node_index);
    cmd.wr_addr         = in_ch.node_index[NODE_AW-1:0];
    cmd.wr_entry.left   = in_ch.left_child;
    cmd.wr_entry.right  = in_ch.right_child;
    cmd.wr_entry.symbol = in_ch.node_symbol;
    cmd.code_bit        = in_ch.code_bit;
  end

endmodule

// ===== design/hwd_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hwd_queue: command queue
// Short first-in first-out buffer between front and back.
// ----------------------------------------------------------------------------
module hwd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  hwd_pkg::cmd_t push_cmd,
  output logic          head_valid,
  output hwd_pkg::cmd_t head_cmd,
  input  logic          pop
);
  import hwd_pkg::*;

  cmd_t            slot_r [QUEUE_DEPTH];
  logic [QA_W-1:0] wr_ptr_r;
  logic [QA_W-1:0] rd_ptr_r;
  logic [QA_W:0]   count_r;
  logic            push;
  logic            pull;

  assign push_ready = (count_r != (QA_W + 1)'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = slot_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pull       = pop && head_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pull) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pull) begin
        count_r <= count_r + 1'b1;
      end else if (pull && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== design/hwd_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hwd_back: node table and tree walk
// Holds the node memory, the current and root entries, and the result stage.
// ----------------------------------------------------------------------------
module hwd_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     head_valid,
  input  hwd_pkg::cmd_t            head_cmd,
  output logic                     pop,
  input  logic                     cfg_we,
  input  logic [hwd_pkg::IDX_W-1:0] cfg_wdata,
  output hwd_pkg::hwd_stat_t       stat,
  hwd_out_if.source                out_ch
);
  import hwd_pkg::*;

  typedef enum logic {
    ST_WALK,
    ST_LOAD_ROOT
  } state_t;

  state_t            state_r;
  logic [IDX_W-1:0]  root_index_r;
  logic              root_stale_r;
  logic              walk_stale_r;
  entry_t            root_e_r;
  entry_t            cur_e_r;
  logic              out_valid_r;
  logic [SYM_W-1:0]  out_sym_r;
  logic              out_bad_r;

  entry_t            node_mem [MAX_NODES];
  entry_t            q_l_r;
  entry_t            q_r_r;

  logic [CHILD_W-1:0] child;
  logic               child_ok;
  entry_t             ce;
  logic               leaf;
  logic               need_out;
  logic               out_space;
  logic               stale;
  logic               is_bit;
  logic               bit_fire;
  logic               wr_fire;
  logic               refill_go;
  entry_t             new_root;
  entry_t             kids_src;
  logic [NODE_AW-1:0] addr_l;
  logic [NODE_AW-1:0] addr_r;

  always_comb begin
    child     = head_cmd.code_bit ? cur_e_r.right : cur_e_r.left;
    child_ok  = child_present(child);
    // The memory outputs hold the entries of both children of the current node.
    ce        = head_cmd.code_bit ? q_r_r : q_l_r;
    leaf      = ce.left[CHILD_W-1] && ce.right[CHILD_W-1];
    need_out  = !child_ok || leaf;
    out_space = !out_valid_r || out_ch.ready;
    stale     = root_stale_r || walk_stale_r;
    is_bit    = head_valid && (head_cmd.kind == CMD_BIT) && (state_r == ST_WALK);
    bit_fire  = is_bit && !stale && (!need_out || out_space);
    wr_fire   = head_valid && (head_cmd.kind == CMD_WRITE) && (state_r == ST_WALK);
    refill_go = is_bit && stale;
    pop       = bit_fire || wr_fire;
    new_root  = idx_in_range(root_index_r) ? q_l_r : MISSING_ENTRY;

    kids_src = cur_e_r;
    case (state_r)
      ST_WALK: begin
        if (bit_fire) begin
          kids_src = need_out ? root_e_r : ce;
        end
      end
      ST_LOAD_ROOT: begin
        kids_src = walk_stale_r ? new_root : cur_e_r;
      end
      default: begin
        kids_src = cur_e_r;
      end
    endcase

    addr_l = kids_src.left[NODE_AW-1:0];
    addr_r = kids_src.right[NODE_AW-1:0];
    if (refill_go) begin
      addr_l = root_index_r[NODE_AW-1:0];
    end
  end

  assign stat.loading          = (state_r == ST_LOAD_ROOT);
  assign stat.stale            = stale;
  assign out_ch.valid          = out_valid_r;
  assign out_ch.decoded_symbol = out_sym_r;
  assign out_ch.bad_path       = out_bad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_WALK;
      root_index_r <= '0;
      root_stale_r <= 1'b1;
      walk_stale_r <= 1'b1;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_WALK: begin
          if (wr_fire) begin
            root_stale_r <= 1'b1;
            walk_stale_r <= 1'b1;
          end
          if (refill_go) begin
            state_r <= ST_LOAD_ROOT;
          end
          if (bit_fire) begin
            if (need_out) begin
              out_valid_r <= 1'b1;
              out_sym_r   <= child_ok ? ce.symbol : '0;
              out_bad_r   <= !child_ok;
              cur_e_r     <= root_e_r;
            end else begin
              cur_e_r <= ce;
            end
          end
        end
        ST_LOAD_ROOT: begin
          root_e_r <= new_root;
          if (walk_stale_r) begin
            cur_e_r <= new_root;
          end
          root_stale_r <= 1'b0;
          walk_stale_r <= 1'b0;
          state_r      <= ST_WALK;
        end
        default: begin
          state_r <= ST_WALK;
        end
      endcase
      if (cfg_we) begin
        root_index_r <= cfg_wdata;
        root_stale_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_fire && head_cmd.wr_ok) begin
      node_mem[head_cmd.wr_addr] <= head_cmd.wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    q_l_r <= node_mem[addr_l];
    q_r_r <= node_mem[addr_r];
  end

endmodule

// ===== design/huffman_tree_walk_decoder_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_tree_walk_decoder_unit: bit-serial Huffman tree-walk decoder
// Stores a node table and walks it one code bit per item, emitting symbols.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake          Item contents
//  in_ch     input      valid / ready      opcode, node_index, left_child,
//                                          right_child, node_symbol, code_bit
//  out_ch    output     valid / ready      decoded_symbol, bad_path
//  cfg_*     input      cfg_we (no ready)  cfg_wdata = root_index
//
// Node writes retire one per cycle while no root reload is under way. Code
// bits also retire one per cycle while the result register has room, leaf
// returns included: the node memory has two read ports that always fetch both
// children of the current node, so the next step only muxes memory outputs.
// The first code bit after a node write or a root_index write waits while the
// root entry and its children are fetched again. Reset is synchronous; the
// node table is not cleared and needs no clearing pass. A stalled result holds
// in the output register while the queue keeps taking items until it is full.
// ----------------------------------------------------------------------------
module huffman_tree_walk_decoder_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  hwd_in_if.sink                    in_ch,
  hwd_out_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic [hwd_pkg::IDX_W-1:0] cfg_wdata
);
  import hwd_pkg::*;

  cmd_t      front_cmd;
  logic      front_valid;
  logic      front_ready;
  cmd_t      head_cmd;
  logic      head_valid;
  logic      cmd_pop;
  hwd_stat_t back_stat;

  // Front end: classifies each input item into a command.
  hwd_front u_front (
    .in_ch     (in_ch),
    .cmd       (front_cmd),
    .cmd_valid (front_valid),
    .cmd_ready (front_ready)
  );

  // Queue decouples the input side from stalls in the tree walk.
  hwd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_cmd   (front_cmd),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (cmd_pop)
  );

  // Back end: node memory, walk state and result register.
  hwd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (cmd_pop),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .stat       (back_stat),
    .out_ch     (out_ch)
  );

  // The back end only retires commands that are really in the queue.
  a_pop_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> head_valid)
    else $error("command retired from an empty queue");

  // A code bit is never walked on a stale root or current entry.
  a_bit_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_pop && head_cmd.kind == CMD_BIT) |-> !back_stat.stale)
    else $error("code bit walked with stale node entries");

  // Reloading the root entry always ends in the cycle after it begins.
  a_load_short: assert property (@(posedge clk) disable iff (!rst_n)
    back_stat.loading |=> !back_stat.loading)
    else $error("root reload did not finish in one cycle");

  // No result is presented right after reset.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result valid after reset");

endmodule

// ===== tb/sv/tb_huffman_tree_walk_decoder_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_huffman_tree_walk_decoder_unit: self-checking bench of the tree-walk decoder
// A short table of directed items is followed by random phases that each load a
// fresh code tree, mostly point root_index at it and stream code bits through it.
// Every result item is checked against a predictor kept inside the bench.
// ----------------------------------------------------------------------------
module tb_huffman_tree_walk_decoder_unit;
  import hwd_pkg::*;

  // Rough number of input items for the whole run.
  localparam int ITEM_TARGET = 1650;
  // Cycles allowed for the block to settle once every result has arrived.
  // Node writes cause no result, so the bench cannot see when they retire.
  localparam int SETTLE_CYCLES = 20;
  // Length of the deliberate receiver hold-off that backs the block up.
  localparam int HOLD_CYCLES = 400;
  // Run limit, several times the slowest legal run.
  localparam int CYCLE_LIMIT = 600000;

  // One input item as the bench sees it.
  typedef struct packed {
    logic              opcode;
    logic [8:0]        node_index;
    logic signed [9:0] left_child;
    logic signed [9:0] right_child;
    logic [7:0]        node_symbol;
    logic              code_bit;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [7:0] decoded_symbol;
    logic       bad_path;
  } out_item_t;

  // A row of the directed table is either an input item or a root_index write.
  typedef enum logic {
    ROW_ITEM = 1'b0,
    ROW_CFG  = 1'b1
  } row_kind_t;

  typedef struct {
    row_kind_t  kind;
    in_item_t   item;
    bit         has_exp;
    out_item_t  exp;
    logic [8:0] cfg_value;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [IDX_W-1:0] cfg_wdata;

  hwd_in_if  in_ch ();
  hwd_out_if out_ch ();

  huffman_tree_walk_decoder_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // Predictor state. The node table mirrors the block's memory; the written
  // flags let the stimulus steer clear of entries that hold no defined value.
  // --------------------------------------------------------------------------
  entry_t     node_mem [MAX_NODES];
  bit         node_written [MAX_NODES];
  int         written_list [$];
  logic [8:0] walk_ptr;
  logic [8:0] root_reg;

  // Results that the block still owes, oldest first.
  out_item_t  expected_symbols [$];

  in_item_t   tree_writes [$];
  dir_row_t   dir_rows [$];

  int  items_accepted;
  int  mismatch_count;
  int  cycle_count;
  // Number of long receiver hold-offs requested so far.
  int  hold_req;
  bit  rx_busy;

  // A child reference is usable when it is non-negative and inside the table.
  function automatic bit child_usable(input logic [9:0] c);
    return !c[9] && (int'(c[8:0]) < MAX_NODES);
  endfunction

  // A leaf is an entry whose children are both missing (sign bits set).
  function automatic bit entry_is_leaf(input entry_t e);
    return e.left[9] && e.right[9];
  endfunction

  function automatic entry_t entry_at(input logic [8:0] idx);
    if (int'(idx) < MAX_NODES) return node_mem[idx];
    return MISSING_ENTRY;
  endfunction

  // Advances the predictor by one accepted item. Returns 1 with the expected
  // result when the item causes one.
  function automatic bit walk_step(input in_item_t it, output out_item_t res);
    entry_t     e;
    entry_t     ce;
    logic [9:0] child;
    res = '0;
    if (it.opcode == OPC_WRITE) begin
      if (int'(it.node_index) < MAX_NODES) begin
        node_mem[it.node_index] = '{left: it.left_child, right: it.right_child,
                                    symbol: it.node_symbol};
        if (!node_written[it.node_index]) begin
          written_list.insert(written_list.size(), int'(it.node_index));
        end
        node_written[it.node_index] = 1'b1;
      end
      walk_ptr = root_reg;
      return 1'b0;
    end
    e = entry_at(walk_ptr);
    child = it.code_bit ? e.right : e.left;
    if (!child_usable(child)) begin
      res.decoded_symbol = '0;
      res.bad_path = 1'b1;
      walk_ptr = root_reg;
      return 1'b1;
    end
    ce = node_mem[child[8:0]];
    if (entry_is_leaf(ce)) begin
      res.decoded_symbol = ce.symbol;
      res.bad_path = 1'b0;
      walk_ptr = root_reg;
      return 1'b1;
    end
    walk_ptr = child[8:0];
    return 1'b0;
  endfunction

  // A code bit is safe when every entry it makes the block read was written.
  function automatic bit bit_is_safe(input logic b);
    entry_t     e;
    logic [9:0] child;
    if (int'(walk_ptr) < MAX_NODES && !node_written[walk_ptr]) return 1'b0;
    e = entry_at(walk_ptr);
    child = b ? e.right : e.left;
    if (child_usable(child) && !node_written[child[8:0]]) return 1'b0;
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Item builders. Fields that the opcode does not use still get random
  // values so that every input bit toggles.
  // --------------------------------------------------------------------------
  function automatic in_item_t node_write(input int idx, input int lc, input int rc,
                                          input int sym);
    in_item_t it;
    it.opcode      = OPC_WRITE;
    it.node_index  = idx[8:0];
    it.left_child  = lc[9:0];
    it.right_child = rc[9:0];
    it.node_symbol = sym[7:0];
    it.code_bit    = 1'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic in_item_t code_bit_item(input logic b);
    in_item_t it;
    it.opcode      = OPC_DECODE;
    it.node_index  = 9'($urandom_range(0, 511));
    it.left_child  = 10'($urandom_range(0, 511)) - 10'sd1;
    it.right_child = 10'($urandom_range(0, 511)) - 10'sd1;
    it.node_symbol = 8'($urandom_range(0, 255));
    it.code_bit    = b;
    return it;
  endfunction

  // A child for a random write: either missing or an entry that already holds
  // data, so that no walk can ever land on an unwritten entry.
  function automatic int pick_child();
    int c;
    if ($urandom_range(0, 3) == 0) return -1;
    do c = written_list[$urandom_range(0, written_list.size() - 1)];
    while (c > 510);
    return c;
  endfunction

  function automatic in_item_t random_write();
    return node_write($urandom_range(0, 511), pick_child(), pick_child(),
                      $urandom_range(0, 255));
  endfunction

  // --------------------------------------------------------------------------
  // Directed table helpers.
  // --------------------------------------------------------------------------
  function automatic void add_write(input int idx, input int lc, input int rc,
                                    input int sym);
    dir_row_t r;
    r.kind = ROW_ITEM;
    r.item = node_write(idx, lc, rc, sym);
    r.has_exp = 1'b0;
    r.exp = '0;
    r.cfg_value = '0;
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  // A code bit whose result is left to the predictor.
  function automatic void add_bit(input logic b);
    dir_row_t r;
    r.kind = ROW_ITEM;
    r.item = code_bit_item(b);
    r.has_exp = 1'b0;
    r.exp = '0;
    r.cfg_value = '0;
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  // A code bit with its result typed in.
  function automatic void add_bit_exp(input logic b, input int sym, input logic bad);
    dir_row_t r;
    r.kind = ROW_ITEM;
    r.item = code_bit_item(b);
    r.has_exp = 1'b1;
    r.exp.decoded_symbol = sym[7:0];
    r.exp.bad_path = bad;
    r.cfg_value = '0;
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  function automatic void add_cfg(input int value);
    dir_row_t r;
    r.kind = ROW_CFG;
    r.item = '0;
    r.has_exp = 1'b0;
    r.exp = '0;
    r.cfg_value = value[8:0];
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  // --------------------------------------------------------------------------
  // Clock, reset and the cycle limit.
  // --------------------------------------------------------------------------
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // The limit only trips when the block stops answering; a correct run ends
  // well inside it.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_huffman_tree_walk_decoder_unit failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sender side. All driving happens at the falling edge; the handshake is
  // sampled at the rising edge. The task is entered and left just after a
  // falling edge, with valid still high for the item that was just taken, so
  // the next call assigns valid exactly once in that step.
  // --------------------------------------------------------------------------
  task automatic drive_item(input in_item_t it, input int gap, input bit has_exp,
                            input out_item_t typed_exp);
    out_item_t res;
    bit        produces;
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid       = 1'b1;
    in_ch.opcode      = it.opcode;
    in_ch.node_index  = it.node_index;
    in_ch.left_child  = it.left_child;
    in_ch.right_child = it.right_child;
    in_ch.node_symbol = it.node_symbol;
    in_ch.code_bit    = it.code_bit;
    do @(posedge clk); while (!in_ch.ready);
    // The item is taken at this edge; its result can only come at a later edge,
    // so the expectation is queued right away.
    items_accepted++;
    produces = walk_step(it, res);
    if (has_exp) expected_symbols.insert(expected_symbols.size(), typed_exp);
    else if (produces) expected_symbols.insert(expected_symbols.size(), res);
    @(negedge clk);
  endtask

  // Writes root_index once the block has gone quiet: every owed result has
  // come back, and trailing node writes have had time to retire.
  task automatic write_root(input logic [8:0] value);
    in_ch.valid = 1'b0;
    while (expected_symbols.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we   = 1'b0;
    root_reg = value;
  endtask

  // Loads a random full code tree. Entries are sent children first so that
  // every child a written entry refers to already holds data. Now and then an
  // internal node loses one child, which makes a broken path.
  task automatic build_tree(input int leaves, output logic [8:0] tree_root);
    int       total;
    int       internals;
    int       next_pos;
    int       p;
    int       c;
    int       slot [128];
    int       lpos [128];
    int       rpos [128];
    bit       taken [MAX_NODES];
    int       open_q [$];
    in_item_t it;
    total     = 2 * leaves - 1;
    internals = leaves - 1;
    foreach (taken[i]) taken[i] = 1'b0;
    // The root may sit at the top entry; children stay inside the field range.
    for (p = 0; p < total; p++) begin
      do c = (p == 0) ? $urandom_range(0, 511) : $urandom_range(0, 510);
      while (taken[c]);
      taken[c] = 1'b1;
      slot[p]  = c;
    end
    // Breadth-first shape: a node becomes internal at random, and always when
    // it is the last open node while internal nodes are still to be placed.
    open_q.insert(open_q.size(), 0);
    next_pos = 1;
    while (open_q.size() > 0) begin
      p = open_q.pop_front();
      if (internals > 0 && (open_q.size() == 0 || $urandom_range(0, 1) == 1)) begin
        lpos[p] = next_pos;
        rpos[p] = next_pos + 1;
        open_q.insert(open_q.size(), next_pos);
        open_q.insert(open_q.size(), next_pos + 1);
        next_pos += 2;
        internals--;
      end else begin
        lpos[p] = -1;
        rpos[p] = -1;
      end
    end
    tree_writes.delete();
    for (p = total - 1; p >= 0; p--) begin
      if (lpos[p] < 0) begin
        it = node_write(slot[p], -1, -1, $urandom_range(0, 255));
      end else begin
        it = node_write(slot[p], slot[lpos[p]], slot[rpos[p]], $urandom_range(0, 255));
        if ($urandom_range(0, 7) == 0) begin
          if ($urandom_range(0, 1) == 1) it.left_child = -10'sd1;
          else it.right_child = -10'sd1;
        end
      end
      tree_writes.insert(tree_writes.size(), it);
    end
    tree_root = 9'(slot[0]);
  endtask

  // --------------------------------------------------------------------------
  // Main stimulus.
  // --------------------------------------------------------------------------
  initial begin
    in_item_t   it;
    logic [8:0] tree_root;
    logic       b;
    int         phase_no;
    int         leaves;
    int         nbits;
    int         pick;
    bit         tx_busy;

    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    in_ch.valid    = 1'b0;
    in_ch.opcode   = OPC_WRITE;
    in_ch.node_index  = '0;
    in_ch.left_child  = '0;
    in_ch.right_child = '0;
    in_ch.node_symbol = '0;
    in_ch.code_bit    = 1'b0;
    items_accepted = 0;
    hold_req       = 0;
    foreach (node_mem[i]) begin
      node_mem[i]     = '0;
      node_written[i] = 1'b0;
    end
    walk_ptr = '0;
    root_reg = '0;

    // Directed part. After reset the root is entry 0 and the pointer is 0.
    // A two-leaf tree at the root: symbols at both byte extremes.
    add_write(5, -1, -1, 8'hFF);
    add_write(6, -1, -1, 8'h00);
    add_write(0, 5, 6, 8'h3C);
    add_bit_exp(1'b0, 8'hFF, 1'b0);
    add_bit_exp(1'b1, 8'h00, 1'b0);
    // Top entries of the table, with an internal node that lacks its left
    // child, so one path through it is broken.
    add_write(510, -1, -1, 8'h81);
    add_write(511, -1, 510, 8'h5A);
    add_write(0, 511, 6, 8'hC3);
    add_bit(1'b0);
    add_bit_exp(1'b0, 8'h00, 1'b1);
    add_bit(1'b0);
    add_bit_exp(1'b1, 8'h81, 1'b0);
    // A lone leaf that will serve as a root of its own.
    add_write(256, -1, -1, 8'h42);
    // Step into entry 511, then move the root: the pointer must stay put
    // until the walk next returns to the root.
    add_bit(1'b0);
    add_cfg(256);
    add_bit_exp(1'b1, 8'h81, 1'b0);
    // Root as a leaf: the walk still steps to a child, which is missing.
    add_bit_exp(1'b1, 8'h00, 1'b1);
    add_bit_exp(1'b0, 8'h00, 1'b1);
    // Highest root index.
    add_cfg(511);
    add_bit_exp(1'b0, 8'h00, 1'b1);
    add_bit_exp(1'b1, 8'h81, 1'b0);
    add_bit_exp(1'b0, 8'h00, 1'b1);
    // Back to the lowest root index. The pointer still sits at entry 511, so
    // the next bit ends that walk at the leaf in entry 510.
    add_cfg(0);
    add_bit_exp(1'b1, 8'h81, 1'b0);
    // A write to the root turns it into a leaf, then makes it internal again.
    add_write(0, -1, -1, 8'h7E);
    add_bit_exp(1'b1, 8'h00, 1'b1);
    add_write(0, 5, 510, 8'h3C);
    add_bit_exp(1'b1, 8'h81, 1'b0);

    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        write_root(dir_rows[i].cfg_value);
      end else begin
        drive_item(dir_rows[i].item, $urandom_range(0, 18), dir_rows[i].has_exp,
                   dir_rows[i].exp);
      end
    end

    // Random part. Each phase loads a tree, usually points the root at it,
    // and then walks it with random bits mixed with a little noise.
    phase_no = 0;
    while (items_accepted < ITEM_TARGET) begin
      phase_no++;
      tx_busy = ($urandom_range(0, 3) == 0);
      // Mostly small trees keep leaves close; a few deep ones stretch walks.
      leaves = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60)
                                           : $urandom_range(1, 12);
      build_tree(leaves, tree_root);
      // Now and then the old root is kept, so the bits walk an older tree that
      // the new writes may have partly overwritten.
      if ($urandom_range(0, 5) != 0) write_root(tree_root);
      foreach (tree_writes[i]) begin
        drive_item(tree_writes[i], tx_busy ? 0 : $urandom_range(0, 18), 1'b0, '0);
      end
      // Two phases run flat out while the receiver holds off, so the block
      // backs up and must stall its input.
      if (phase_no == 3 || phase_no == 12) begin
        tx_busy  = 1'b1;
        hold_req = hold_req + 1;
      end
      nbits = $urandom_range(20, 80);
      repeat (nbits) begin
        pick = $urandom_range(0, 99);
        b = 1'($urandom_range(0, 1));
        if (pick < 90) begin
          if (bit_is_safe(b)) begin
            drive_item(code_bit_item(b), tx_busy ? 0 : $urandom_range(0, 18), 1'b0, '0);
          end
        end else begin
          it = random_write();
          drive_item(it, tx_busy ? 0 : $urandom_range(0, 18), 1'b0, '0);
        end
      end
    end

    // Drain: every owed result must arrive, then the block is left to settle in
    // case it emits something unexpected.
    in_ch.valid = 1'b0;
    while (expected_symbols.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("tb_huffman_tree_walk_decoder_unit passed");
    end else begin
      $display("tb_huffman_tree_walk_decoder_unit failed");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver side. Ready changes at the falling edge; each accepted result is
  // compared with the oldest expectation.
  // --------------------------------------------------------------------------
  initial begin
    out_item_t exp;
    int        gap;
    int        holds_done;
    out_ch.ready = 1'b0;
    rx_busy      = 1'b0;
    holds_done   = 0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (hold_req != holds_done) begin
        holds_done   = hold_req;
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        gap = rx_busy ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
          out_ch.ready = 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      if (expected_symbols.size() == 0) begin
        $error("result item with no expectation: decoded_symbol %0h bad_path %0b",
               out_ch.decoded_symbol, out_ch.bad_path);
        mismatch_count++;
      end else begin
        exp = expected_symbols.pop_front();
        if (out_ch.decoded_symbol !== exp.decoded_symbol) begin
          $error("decoded_symbol mismatch: expected %0h actual %0h",
                 exp.decoded_symbol, out_ch.decoded_symbol);
          mismatch_count++;
        end
        if (out_ch.bad_path !== exp.bad_path) begin
          $error("bad_path mismatch: expected %0b actual %0b",
                 exp.bad_path, out_ch.bad_path);
          mismatch_count++;
        end
      end
      // Switch between random stalls and stretches of steady acceptance.
      if ($urandom_range(0, 39) == 0) rx_busy = !rx_busy;
      @(negedge clk);
    end
  end

endmodule
